/* hw/rtl/spt_pkg.sv */
// Shared types and constants for the slot pool with time-to-live eviction.
`timescale 1ns / 1ps

package spt_pkg;

  localparam int unsigned SLOT_W = 6;
  localparam int unsigned LIFE_W = 6;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [LIFE_W-1:0] HOLD_RESET = 6'h3C;
  localparam logic [LIFE_W-1:0] NEW_LIFE   = 6'd1;

  // Command codes; the two remaining codes change nothing
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TOUCH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd5;

  // Register select taken from the word address bit
  localparam logic REG_HOLD_TICKS = 1'b0;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic              success;
    logic              fresh_buffer;
    logic              buffer_present;
  } res_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic              apply;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] idx;
    logic [LIFE_W-1:0] hold;
  } cell_ctl_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic hit_buf;
    logic grant;
  } cell_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EMIT
  } seq_state_t;

endpackage

/* hw/rtl/spt_stream_if.sv */
// Valid/ready stream channel carrying one payload of a chosen type.
`timescale 1ns / 1ps

interface spt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/spt_cell.sv */
// One slot of the pool: flags, life counter and the allocate search token.
`timescale 1ns / 1ps

module spt_cell
  import spt_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  logic       token_in,
  output logic       token_out,
  output cell_stat_t stat
);

  localparam bit                ADDRESSABLE = (INDEX < 64);
  localparam logic [SLOT_W-1:0] MY_IDX      = SLOT_W'(INDEX);

  logic              allocated, allocated_next;
  logic              buffered, buffered_next;
  logic [LIFE_W-1:0] life, life_next;
  logic              search;
  logic              match;
  logic              claim;

  // Decode own address and the search token
  assign match     = ADDRESSABLE && (ctl.idx == MY_IDX);
  assign claim     = search & ~allocated;
  assign token_out = search & allocated;

  assign stat.hit_buf = match & buffered;
  assign stat.grant   = claim;

  // Work out the next slot state for this cycle's command
  always_comb begin
    allocated_next = allocated;
    buffered_next  = buffered;
    life_next      = life;
    if (claim) begin
      allocated_next = 1'b1;
      buffered_next  = 1'b0;
      life_next      = NEW_LIFE;
    end else if (ctl.apply) begin
      case (ctl.mode)
        MODE_RELEASE: begin
          if (match) begin
            allocated_next = 1'b0;
            buffered_next  = 1'b0;
            life_next      = '0;
          end
        end
        MODE_TOUCH: begin
          if (match) begin
            life_next     = ctl.hold;
            buffered_next = 1'b1;
          end
        end
        MODE_TICK: begin
          if (allocated && buffered) begin
            if (life <= LIFE_W'(1)) buffered_next = 1'b0;
            if (life != '0) life_next = life - LIFE_W'(1);
          end
        end
        MODE_FLUSH: begin
          if (allocated) begin
            life_next     = '0;
            buffered_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold slot state, pass the token on each cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      allocated <= 1'b0;
      buffered  <= 1'b0;
      life      <= '0;
      search    <= 1'b0;
    end else begin
      allocated <= allocated_next;
      buffered  <= buffered_next;
      life      <= life_next;
      search    <= token_in;
    end
  end

endmodule

/* hw/rtl/slot_pool_with_ttl_eviction.sv */
// Top level of the slot pool with time-to-live eviction.
//
// Commands arrive as transactions on the cmd channel (mode, slot_index) and
// each one produces exactly one transaction on the res channel (result_slot,
// success, fresh_buffer, buffer_present). Commands are handled one at a time.
// For release, touch, tick, flush-all, query and unknown codes, every slot
// cell updates in the acceptance cycle and the addressed cell is read back
// the cycle after.
// Allocate walks a search token down the row of cells, one cell per cycle,
// so its search time grows with the index of the lowest free slot; that
// walk sets the allocate rate.
// A new command is taken only after the previous one has loaded its result
// into the output register.
// A finished result sits in the output register while the next command is
// taken; if the receiver stalls with a result still waiting, the block holds
// the next result internally and accepts nothing further until it drains.
// The hold_ticks register is written over the APB port at address 0.
// Synchronous reset empties the pool (all slots free, no buffers, life 0)
// and loads hold_ticks with 60.
`timescale 1ns / 1ps

module slot_pool_with_ttl_eviction
  import spt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst,
  spt_stream_if.sink        cmd,
  spt_stream_if.source      res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned REACH = (SLOT_COUNT < 64) ? SLOT_COUNT : 64;
  localparam int unsigned POS_W = (REACH > 1) ? $clog2(REACH) : 1;

  seq_state_t        state, state_next;
  logic [LIFE_W-1:0] hold_ticks;
  logic [MODE_W-1:0] cmd_mode;
  logic [SLOT_W-1:0] cmd_idx;
  logic              pre_buffered;
  logic [POS_W-1:0]  scan_pos;
  res_t              pending;
  res_t              out_data;
  logic              out_valid;

  logic              accept;
  logic              start;
  logic              out_load;
  logic              grant_any;
  logic              fail;
  logic              any_hit;
  logic              in_pool;
  cell_ctl_t         ctl;

  logic [SLOT_COUNT-1:0] token;
  logic [SLOT_COUNT-1:0] pass;
  logic [SLOT_COUNT-1:0] hit_vec;
  logic [SLOT_COUNT-1:0] grant_vec;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HOLD_TICKS) ? APB_DW'(hold_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_HOLD_TICKS)) begin
      hold_ticks <= pwdata[LIFE_W-1:0];
    end
  end

  // Handshake terms
  assign accept   = cmd.valid & cmd.ready;
  assign start    = accept & (cmd.data.mode == MODE_ALLOC);
  assign out_load = (state == ST_EMIT) && (!out_valid || res.ready);

  // Broadcast to the cells: live command on acceptance, held index afterwards
  assign ctl.apply = accept;
  assign ctl.mode  = cmd.data.mode;
  assign ctl.idx   = (state == ST_IDLE) ? cmd.data.slot_index : cmd_idx;
  assign ctl.hold  = hold_ticks;

  // Row of slot cells with the search token chain
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    cell_stat_t cstat;

    if (i == 0) begin : g_head
      assign token[i] = start;
    end else if (i < REACH) begin : g_link
      assign token[i] = pass[i-1];
    end else begin : g_tail
      assign token[i] = 1'b0;
    end

    spt_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .token_in (token[i]),
      .token_out(pass[i]),
      .stat     (cstat)
    );

    assign hit_vec[i]   = cstat.hit_buf;
    assign grant_vec[i] = cstat.grant;
  end

  assign any_hit   = |hit_vec;
  assign grant_any = |grant_vec;
  assign fail      = pass[REACH-1];
  assign in_pool   = (32'(cmd_idx) < SLOT_COUNT);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = (cmd.data.mode == MODE_ALLOC) ? ST_SCAN : ST_READ;
      end
      ST_SCAN: begin
        if (grant_any || fail) state_next = ST_EMIT;
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd.ready = 1'b0;
    unique case (state)
      ST_IDLE: cmd.ready = 1'b1;
      default: cmd.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the command and form the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode     <= cmd.data.mode;
      cmd_idx      <= cmd.data.slot_index;
      pre_buffered <= any_hit;
      scan_pos     <= '0;
    end else if (state == ST_SCAN) begin
      scan_pos <= scan_pos + POS_W'(1);
    end

    if (state == ST_SCAN) begin
      if (grant_any) begin
        pending.result_slot    <= SLOT_W'(scan_pos);
        pending.success        <= 1'b1;
        pending.fresh_buffer   <= 1'b0;
        pending.buffer_present <= 1'b0;
      end else if (fail) begin
        pending <= '0;
      end
    end else if (state == ST_READ) begin
      pending.result_slot    <= cmd_idx;
      pending.success        <= 1'b1;
      pending.fresh_buffer   <= (cmd_mode == MODE_TOUCH) & in_pool & ~pre_buffered;
      pending.buffer_present <= any_hit;
    end

    if (out_load) begin
      out_data <= pending;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

  // Only one cell may claim during a search
  a_single_grant: assert property (@(posedge clk) disable iff (rst)
    $onehot0(grant_vec))
    else $error("more than one slot granted in a cycle");

  // Claims happen only while searching
  a_grant_in_scan: assert property (@(posedge clk) disable iff (rst)
    grant_any |-> (state == ST_SCAN))
    else $error("slot claimed outside a search");

  // Search position stays within reach
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (32'(scan_pos) < REACH))
    else $error("search ran past the last reachable slot");

  // A loaded result is presented next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> res.valid)
    else $error("result lost at the output register");

endmodule

/* dv/spt_pool_checker.sv */
// Checker for the slot pool: mirrors pool state and compares result transactions.
`timescale 1ns / 1ps

module spt_pool_checker
  import spt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_ready,
  input  cmd_t              cmd_data,
  input  logic              res_valid,
  input  logic              res_ready,
  input  res_t              res_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending
);

  // Allocate can only grant slots that a slot index can name
  localparam int unsigned GRANT_REACH =
    (SLOT_COUNT < (1 << SLOT_W)) ? SLOT_COUNT : (1 << SLOT_W);

  logic              slot_taken    [SLOT_COUNT];
  logic              slot_buffered [SLOT_COUNT];
  logic [LIFE_W-1:0] slot_life     [SLOT_COUNT];
  logic [LIFE_W-1:0] hold_value;
  res_t              expected_outcomes [$];

  // Apply one command to the mirrored pool and return the result it must give
  function automatic res_t apply_command(cmd_t c);
    res_t r;
    logic in_pool;
    int   free_slot;
    r = '{result_slot: c.slot_index, success: 1'b1, fresh_buffer: 1'b0,
          buffer_present: 1'b0};
    in_pool   = int'(c.slot_index) < SLOT_COUNT;
    free_slot = -1;
    case (c.mode)
      MODE_ALLOC: begin
        // lowest free slot wins
        for (int i = GRANT_REACH - 1; i >= 0; i--) begin
          if (!slot_taken[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          slot_taken[free_slot]    = 1'b1;
          slot_buffered[free_slot] = 1'b0;
          slot_life[free_slot]     = NEW_LIFE;
          r.result_slot            = free_slot[SLOT_W-1:0];
        end else begin
          r.result_slot = '0;
          r.success     = 1'b0;
        end
      end
      MODE_RELEASE: begin
        if (in_pool) begin
          slot_taken[c.slot_index]    = 1'b0;
          slot_buffered[c.slot_index] = 1'b0;
          slot_life[c.slot_index]     = '0;
        end
      end
      MODE_TOUCH: begin
        if (in_pool) begin
          slot_life[c.slot_index]     = hold_value;
          r.fresh_buffer              = !slot_buffered[c.slot_index];
          slot_buffered[c.slot_index] = 1'b1;
        end
      end
      MODE_TICK: begin
        // count down live buffers; drop any whose life runs out
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_taken[i] && slot_buffered[i]) begin
            if (slot_life[i] <= 1) slot_buffered[i] = 1'b0;
            if (slot_life[i] != 0) slot_life[i] = slot_life[i] - 1'b1;
          end
        end
      end
      MODE_FLUSH: begin
        // free slots keep their buffers
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_taken[i]) begin
            slot_life[i]     = '0;
            slot_buffered[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    // every command but allocate reports the addressed slot after the update
    if (c.mode != MODE_ALLOC && in_pool) r.buffer_present = slot_buffered[c.slot_index];
    return r;
  endfunction

  function automatic int field_mismatch(string field, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : observe
    int   errs;
    res_t want;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_taken[i]    = 1'b0;
        slot_buffered[i] = 1'b0;
        slot_life[i]     = '0;
      end
      hold_value = HOLD_RESET;
      expected_outcomes.delete();
    end else begin
      // compare the result transaction with the oldest expectation
      if (res_valid && res_ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result transaction with nothing expected: result_slot %0d",
                 res_data.result_slot);
          errs++;
        end else begin
          want = expected_outcomes.pop_front();
          errs += field_mismatch("result_slot", 32'(want.result_slot),
                                 32'(res_data.result_slot));
          errs += field_mismatch("success", 32'(want.success), 32'(res_data.success));
          errs += field_mismatch("fresh_buffer", 32'(want.fresh_buffer),
                                 32'(res_data.fresh_buffer));
          errs += field_mismatch("buffer_present", 32'(want.buffer_present),
                                 32'(res_data.buffer_present));
        end
      end
      if (cmd_valid && cmd_ready) expected_outcomes.push_back(apply_command(cmd_data));
      // track the hold register as it is written
      if (psel && penable && pwrite && pready && paddr[2] == REG_HOLD_TICKS)
        hold_value = pwdata[LIFE_W-1:0];
    end
    fail_count <= fail_count + errs;
    pending    <= expected_outcomes.size();
  end

endmodule

/* dv/tb_slot_pool_with_ttl_eviction.sv */
// Testbench top for the slot pool: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_slot_pool_with_ttl_eviction;
  import spt_pkg::*;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 195;
  localparam int unsigned MIX_WAYS        = 7;

  // Codes the block does not decode
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  // Command mix per phase in percent:
  // allocate, release, touch, tick, flush, query, undecoded
  localparam int unsigned MIX [PHASES][MIX_WAYS] = '{
    '{60,  5, 15, 10, 2, 6, 2},
    '{40, 10, 25, 15, 2, 6, 2},
    '{20, 20, 25, 20, 3, 10, 2},
    '{25, 15, 25, 25, 2, 6, 2},
    '{10, 45, 20, 15, 2, 6, 2},
    '{35, 10, 25, 20, 2, 6, 2},
    '{65,  3, 15, 10, 1, 5, 1},
    '{15, 30, 25, 20, 3, 5, 2}
  };
  localparam int unsigned IDLE_PCT  [PHASES] = '{0, 70, 0, 38, 0, 70, 0, 38};
  localparam int unsigned STALL_PCT [PHASES] = '{0, 0, 70, 38, 0, 0, 70, 38};
  // Hold setting per phase; a negative entry picks one at random
  localparam int          HOLD_SET  [PHASES] = '{1, 63, 0, 2, 5, -1, 3, 60};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;

  spt_stream_if #(.T(cmd_t)) cmd_ch ();
  spt_stream_if #(.T(res_t)) res_ch ();

  slot_pool_with_ttl_eviction dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  spt_pool_checker pool_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_ch.valid),
    .cmd_ready  (cmd_ch.ready),
    .cmd_data   (cmd_ch.data),
    .res_valid  (res_ch.valid),
    .res_ready  (res_ch.ready),
    .res_data   (res_ch.data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the result channel at the rate of the current phase
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one command and hold it until the block takes the transaction
  task automatic issue(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= cmd_t'{mode: m, slot_index: s};
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write hold_ticks: setup cycle, then access until pready; junk in the upper bits
  task automatic write_hold(input logic [LIFE_W-1:0] v);
    logic [APB_DW-1:0] upper;
    upper   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HOLD_TICKS, 2'b00};
    pwdata  <= {upper[APB_DW-1:LIFE_W], v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [MODE_W-1:0] pick_mode(int unsigned p);
    int unsigned roll;
    int unsigned acc;
    logic [MODE_W-1:0] codes [MIX_WAYS];
    codes = '{MODE_ALLOC, MODE_RELEASE, MODE_TOUCH, MODE_TICK, MODE_FLUSH, MODE_QUERY,
              MODE_SPARE_LO};
    roll = $urandom_range(99);
    acc  = 0;
    for (int k = 0; k < MIX_WAYS - 1; k++) begin
      acc += MIX[p][k];
      if (roll < acc) return codes[k];
    end
    return $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
  endfunction

  // Favour the low slots, where allocations land, but reach the whole range too
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(1)) return SLOT_W'($urandom_range((1 << SLOT_W) - 1));
    return SLOT_W'($urandom_range(7));
  endfunction

  initial begin
    int hold;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.data    <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    rst            <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty pool, undecoded codes and touch of a free slot at reset hold
    issue(MODE_QUERY, 6'd0);
    issue(MODE_QUERY, 6'd63);
    issue(MODE_TICK, 6'd63);
    issue(MODE_FLUSH, 6'd42);
    issue(MODE_SPARE_LO, 6'd63);
    issue(MODE_SPARE_HI, 6'd21);
    issue(MODE_TOUCH, 6'd5);
    issue(MODE_TOUCH, 6'd5);
    issue(MODE_ALLOC, 6'd63);
    issue(MODE_ALLOC, 6'd0);
    issue(MODE_TOUCH, 6'd0);
    issue(MODE_TICK, 6'd0);
    // flush drops slot 0's buffer but leaves the free slot 5 alone
    issue(MODE_FLUSH, 6'd5);
    issue(MODE_QUERY, 6'd0);
    issue(MODE_RELEASE, 6'd1);
    issue(MODE_RELEASE, 6'd63);
    issue(MODE_ALLOC, 6'd0);

    // Zero hold: next tick drops an allocated buffer, not a free one
    drain_results();
    write_hold(6'd0);
    issue(MODE_TOUCH, 6'd1);
    issue(MODE_TICK, 6'd1);
    issue(MODE_TOUCH, 6'd5);
    issue(MODE_TICK, 6'd5);

    // Hold of one expires on the first tick
    drain_results();
    write_hold(6'd1);
    issue(MODE_TOUCH, 6'd0);
    issue(MODE_TICK, 6'd0);
    issue(MODE_RELEASE, 6'd0);
    issue(MODE_RELEASE, 6'd1);

    // Random phases: fill, churn and drain under varying hold and flow control
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      hold = (HOLD_SET[p] < 0) ? int'($urandom_range(1, 63)) : HOLD_SET[p];
      write_hold(hold[LIFE_W-1:0]);
      send_idle_pct  <= IDLE_PCT[p];
      recv_stall_pct <= STALL_PCT[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) issue(pick_mode(p), pick_slot());
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("slot_pool_with_ttl_eviction verification clean");
    end else begin
      $display("slot_pool_with_ttl_eviction verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #8_000_000;
    $display("slot_pool_with_ttl_eviction verification failed");
    $finish;
  end

endmodule
